// File: hdl/smi_pkg.sv
// Shared constants, types and state encoding for the momentum index unit.
package smi_pkg;

    localparam int WINDOW_MAX = 64;
    localparam int ADDR_W     = $clog2(WINDOW_MAX);
    localparam int LEN_W      = ADDR_W + 1;
    localparam int PRICE_BITS = 24;
    localparam int FRAC_BITS  = 16;
    localparam int AVG_W      = 48;
    localparam int CFG_W      = 17;
    localparam int IDX_W      = 2;
    localparam int ALPHA_ONE  = 65536;

    typedef enum logic [IDX_W-1:0] {
        REG_WINDOW_LENGTH = 2'd0,
        REG_FAST_ALPHA    = 2'd1,
        REG_SLOW_ALPHA    = 2'd2
    } smi_reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CALC,
        ST_MUL,
        ST_ADD,
        ST_DSTART,
        ST_DIV,
        ST_OUT
    } smi_state_t;

endpackage

// File: hdl/stochastic_momentum_index_unit.sv
// Stochastic momentum index: one request is one bar (high, low, close).
// An extreme that ages out adds a rescan of the stored window (one RAM read per cycle).
// A zero operand or a saturated ratio skips the serial steps of the divider.
// Warm-up bars give no result; after the calc state the unit returns to idle.
// One bar in flight; a waiting result holds only ST_OUT.
// Reset (async, active low) clears extremes, averages and warm-up; window RAM is not cleared.
module stochastic_momentum_index_unit
    import smi_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [PRICE_BITS-1:0]        high_price,
    input  logic [PRICE_BITS-1:0]        low_price,
    input  logic [PRICE_BITS-1:0]        close_price,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [15:0]           smi_value,
    input  logic                         cfg_wr_en,
    input  logic [IDX_W-1:0]             cfg_index,
    input  logic [CFG_W-1:0]             cfg_data
);

    smi_state_t state_reg, state_next;

    // configuration
    logic [LEN_W-1:0] win_len_reg;
    logic [CFG_W-1:0] fast_alpha_reg;
    logic [CFG_W-1:0] slow_alpha_reg;
    logic [LEN_W-1:0] len_eff;
    logic [CFG_W-1:0] fa_eff;
    logic [CFG_W-1:0] sa_eff;

    // window tracking
    logic [ADDR_W-1:0]     wp_reg;
    logic [PRICE_BITS-1:0] hh_reg;
    logic [PRICE_BITS-1:0] ll_reg;
    logic [LEN_W-1:0]      hage_reg;
    logic [LEN_W-1:0]      lage_reg;
    logic [LEN_W-1:0]      hage_inc;
    logic [LEN_W-1:0]      lage_inc;
    logic                  rescan_h_reg;
    logic                  rescan_l_reg;
    logic [LEN_W-1:0]      iss_reg;
    logic                  rd_vld_reg;
    logic [LEN_W-1:0]      rd_age_reg;
    logic                  issue;
    logic [LEN_W-1:0]      warm_reg;
    logic [PRICE_BITS-1:0] close_reg;

    // RAM
    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [ADDR_W-1:0]       ram_raddr;
    logic [2*PRICE_BITS-1:0] ram_rdata;
    logic [PRICE_BITS-1:0]   rd_high;
    logic [PRICE_BITS-1:0]   rd_low;

    // averages
    logic signed [AVG_W-1:0] fn_reg, sn_reg, fd_reg, sd_reg;
    logic signed [AVG_W-1:0] xnum_reg, xden_reg;
    logic signed [AVG_W-1:0] num_c, den_c;
    logic [1:0]              step_reg;
    logic signed [AVG_W-1:0] ema_avg, ema_x;
    logic [CFG_W-1:0]        ema_alpha;
    logic signed [AVG_W:0]   ema_d;
    logic signed [CFG_W:0]   ema_a;
    logic signed [AVG_W+CFG_W+1:0] prod_c, prod_reg, rnd;
    logic signed [AVG_W-1:0] ema_new;

    // output
    logic               div_start;
    logic               div_done;
    logic signed [15:0] div_result;
    logic               out_valid_reg;
    logic signed [15:0] smi_reg;
    logic signed [15:0] smi_out_reg;
    logic               accept;
    logic               out_load;
    logic               warm_more;

    // register clamps
    always_comb
    begin
        if (win_len_reg == '0)
            len_eff = LEN_W'(1);
        else if (win_len_reg > LEN_W'(WINDOW_MAX))
            len_eff = LEN_W'(WINDOW_MAX);
        else
            len_eff = win_len_reg;
        fa_eff = (fast_alpha_reg == '0) ? CFG_W'(1) :
                 (fast_alpha_reg > CFG_W'(ALPHA_ONE)) ? CFG_W'(ALPHA_ONE) : fast_alpha_reg;
        sa_eff = (slow_alpha_reg == '0) ? CFG_W'(1) :
                 (slow_alpha_reg > CFG_W'(ALPHA_ONE)) ? CFG_W'(ALPHA_ONE) : slow_alpha_reg;
    end

    assign accept   = (state_reg == ST_IDLE) && in_valid;
    assign in_ready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    // ages saturate at the window capacity
    assign hage_inc = (hage_reg == LEN_W'(WINDOW_MAX)) ? hage_reg : hage_reg + LEN_W'(1);
    assign lage_inc = (lage_reg == LEN_W'(WINDOW_MAX)) ? lage_reg : lage_reg + LEN_W'(1);

    // circular window: newest bar at wp_reg, age j at wp_reg - j
    assign ram_we    = accept;
    assign ram_waddr = wp_reg + ADDR_W'(1);
    assign ram_raddr = wp_reg - iss_reg[ADDR_W-1:0];
    assign issue     = (state_reg == ST_SCAN) && (iss_reg < len_eff);
    assign rd_high   = ram_rdata[2*PRICE_BITS-1:PRICE_BITS];
    assign rd_low    = ram_rdata[PRICE_BITS-1:0];

    smi_ram #(
        .WIDTH (2*PRICE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_window_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({high_price, low_price}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // num = close*2^F - (hh+ll)*2^(F-1), den = (hh-ll)*2^F
    assign num_c = AVG_W'($signed({1'b0, close_reg, FRAC_BITS'(0)}))
                 - AVG_W'($signed({1'b0, {1'b0, hh_reg} + {1'b0, ll_reg}, (FRAC_BITS-1)'(0)}));
    assign den_c = AVG_W'($signed({$signed({1'b0, hh_reg} - {1'b0, ll_reg}),
                                   FRAC_BITS'(0)}));
    assign warm_more = (warm_reg + LEN_W'(1)) < len_eff;

    // one shared EMA unit: fast num, slow num, fast den, slow den
    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                ema_avg = fn_reg; ema_x = xnum_reg; ema_alpha = fa_eff;
            end
            2'd1:
            begin
                ema_avg = sn_reg; ema_x = fn_reg; ema_alpha = sa_eff;
            end
            2'd2:
            begin
                ema_avg = fd_reg; ema_x = xden_reg; ema_alpha = fa_eff;
            end
            default:
            begin
                ema_avg = sd_reg; ema_x = fd_reg; ema_alpha = sa_eff;
            end
        endcase
    end

    assign ema_d   = {ema_x[AVG_W-1], ema_x} - {ema_avg[AVG_W-1], ema_avg};
    assign ema_a   = $signed({1'b0, ema_alpha});
    assign prod_c  = ema_d * ema_a;
    assign rnd     = prod_reg + (AVG_W+CFG_W+2)'(32768);
    assign ema_new = ema_avg + AVG_W'(rnd >>> 16);

    assign div_start = (state_reg == ST_DSTART);

    smi_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (sn_reg),
        .den    (sd_reg),
        .done   (div_done),
        .result (div_result)
    );

    // next-state logic
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!issue && !rd_vld_reg)
                    state_next = ST_CALC;
            end
            ST_CALC:
            begin
                if (warm_more)
                    state_next = ST_IDLE;
                else if ((warm_reg + LEN_W'(1)) == len_eff)
                    state_next = ST_DSTART;
                else
                    state_next = ST_MUL;
            end
            ST_MUL:
                state_next = ST_ADD;
            ST_ADD:
                state_next = (step_reg == 2'd3) ? ST_DSTART : ST_MUL;
            ST_DSTART:
                state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len_reg    <= LEN_W'(10);
            fast_alpha_reg <= CFG_W'(32768);
            slow_alpha_reg <= CFG_W'(32768);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_WINDOW_LENGTH: win_len_reg    <= cfg_data[LEN_W-1:0];
                REG_FAST_ALPHA:    fast_alpha_reg <= cfg_data;
                REG_SLOW_ALPHA:    slow_alpha_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // window extremes, warm-up and averages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            hh_reg       <= '0;
            ll_reg       <= '1;
            hage_reg     <= '0;
            lage_reg     <= '0;
            rescan_h_reg <= 1'b0;
            rescan_l_reg <= 1'b0;
            iss_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            rd_age_reg   <= '0;
            warm_reg     <= '0;
            fn_reg       <= '0;
            sn_reg       <= '0;
            fd_reg       <= '0;
            sd_reg       <= '0;
            step_reg     <= 2'd0;
        end
        else
        begin
            rd_vld_reg <= issue;
            rd_age_reg <= iss_reg;
            if (issue)
                iss_reg <= iss_reg + LEN_W'(1);

            if (accept)
            begin
                wp_reg    <= wp_reg + ADDR_W'(1);
                close_reg <= close_price;
                // read the window only when an extreme ages out
                iss_reg   <= (hage_inc >= len_eff || lage_inc >= len_eff) ?
                             LEN_W'(1) : len_eff;
                // high side: rescan when the extreme ages out, newest wins ties
                rescan_h_reg <= hage_inc >= len_eff;
                if (hage_inc >= len_eff || high_price >= hh_reg)
                begin
                    hh_reg   <= high_price;
                    hage_reg <= '0;
                end
                else
                begin
                    hage_reg <= hage_inc;
                end
                rescan_l_reg <= lage_inc >= len_eff;
                if (lage_inc >= len_eff || low_price <= ll_reg)
                begin
                    ll_reg   <= low_price;
                    lage_reg <= '0;
                end
                else
                begin
                    lage_reg <= lage_inc;
                end
            end

            // scan runs from newest to oldest, strict compare keeps the newest
            if (state_reg == ST_SCAN && rd_vld_reg)
            begin
                if (rescan_h_reg && rd_high > hh_reg)
                begin
                    hh_reg   <= rd_high;
                    hage_reg <= rd_age_reg;
                end
                if (rescan_l_reg && rd_low < ll_reg)
                begin
                    ll_reg   <= rd_low;
                    lage_reg <= rd_age_reg;
                end
            end

            if (state_reg == ST_CALC)
            begin
                xnum_reg <= num_c;
                xden_reg <= den_c;
                step_reg <= 2'd0;
                if (warm_reg != LEN_W'(WINDOW_MAX))
                    warm_reg <= warm_reg + LEN_W'(1);
                if (!warm_more && (warm_reg + LEN_W'(1)) == len_eff)
                begin
                    // first full window seeds every average
                    fn_reg <= num_c;
                    sn_reg <= num_c;
                    fd_reg <= den_c;
                    sd_reg <= den_c;
                end
            end

            if (state_reg == ST_MUL)
                prod_reg <= prod_c;

            if (state_reg == ST_ADD)
            begin
                step_reg <= step_reg + 2'd1;
                case (step_reg)
                    2'd0:    fn_reg <= ema_new;
                    2'd1:    sn_reg <= ema_new;
                    2'd2:    fd_reg <= ema_new;
                    default: sd_reg <= ema_new;
                endcase
            end
        end
    end

    // result register, holds while the consumer stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DIV && div_done)
            smi_reg <= div_result;
        else if (out_load)
            smi_out_reg <= smi_reg;
    end

    assign out_valid = out_valid_reg;
    assign smi_value = smi_out_reg;

endmodule

// File: hdl/smi_ram.sv
// Generic single-write, single-read RAM with registered read data.
module smi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/smi_div.sv
// Serial divider: 200*num/den in Q8.8, rounded half away from zero, saturated.
module smi_div
    import smi_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [AVG_W-1:0] num,
    input  logic signed [AVG_W-1:0] den,
    output logic                    done,
    output logic signed [15:0]      result
);

    logic [AVG_W-1:0]   a_abs;
    logic [AVG_W-1:0]   b_abs;
    logic [AVG_W+4:0]   scaled;
    logic               neg;
    logic [AVG_W-1:0]   b_reg;
    logic [AVG_W:0]     r_reg;
    logic [15:0]        ns_reg;
    logic [15:0]        f_reg;
    logic [4:0]         cnt_reg;
    logic               busy_reg;
    logic               neg_reg;
    logic               done_reg;
    logic signed [15:0] result_reg;
    logic [AVG_W:0]     r_shift;
    logic [16:0]        mag;

    assign a_abs   = num[AVG_W-1] ? AVG_W'(-num) : AVG_W'(num);
    assign b_abs   = den[AVG_W-1] ? AVG_W'(-den) : AVG_W'(den);
    assign neg     = num[AVG_W-1] != den[AVG_W-1];
    // 25*a as 16a + 8a + a
    assign scaled  = ({5'd0, a_abs} << 4) + ({5'd0, a_abs} << 3) + {5'd0, a_abs};
    assign r_shift = {r_reg[AVG_W-1:0], ns_reg[15]};
    assign mag     = (17'(f_reg) + 17'd1) >> 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (num == '0 || den == '0)
                begin
                    result_reg <= 16'sd0;
                    done_reg   <= 1'b1;
                end
                else if (scaled >= {1'b0, b_abs, 4'd0})
                begin
                    // quotient of 25a/b at least 16: out of Q8.8 range
                    result_reg <= neg ? -16'sd32768 : 16'sd32767;
                    done_reg   <= 1'b1;
                end
                else
                begin
                    b_reg    <= b_abs;
                    r_reg    <= scaled[AVG_W+4:4];
                    ns_reg   <= {scaled[3:0], 12'd0};
                    f_reg    <= 16'd0;
                    neg_reg  <= neg;
                    cnt_reg  <= 5'd16;
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 5'd0)
                begin
                    busy_reg   <= 1'b0;
                    done_reg   <= 1'b1;
                    if (neg_reg)
                    begin
                        result_reg <= 16'(-$signed({1'b0, mag}));
                    end
                    else
                    begin
                        result_reg <= (mag > 17'd32767) ? 16'sd32767 : 16'(mag);
                    end
                end
                else
                begin
                    cnt_reg <= cnt_reg - 5'd1;
                    ns_reg  <= {ns_reg[14:0], 1'b0};
                    if (r_shift >= {1'b0, b_reg})
                    begin
                        r_reg <= r_shift - {1'b0, b_reg};
                        f_reg <= {f_reg[14:0], 1'b1};
                    end
                    else
                    begin
                        r_reg <= r_shift;
                        f_reg <= {f_reg[14:0], 1'b0};
                    end
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: hdl/smi_checker.sv
// Port-level checks for the momentum index unit, bound to the top level.
module smi_port_props
    import smi_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] smi_value
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(smi_value))
        else $error("result changed while stalled");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while one is in flight");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared one cycle after a request");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind stochastic_momentum_index_unit smi_port_props u_smi_port_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .smi_value (smi_value)
);
